>>> sv/tdtp_pkg.sv
// Shared types and constants for the time-of-day text parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tdtp_pkg;

  // Default for the text buffer depth.
  localparam int unsigned MAX_TEXT_CHARS_DEF = 32;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Parse limits.
  localparam int unsigned RUN_MAX_DIGITS = 4;
  localparam int unsigned HOUR_MAX       = 23;
  localparam int unsigned MINUTE_MAX     = 59;
  localparam int unsigned NOON_HOUR      = 12;
  localparam int unsigned PM_OFFSET      = 12;

  // Character class: values 0 to 9 are the digit values themselves.
  typedef logic [4:0] cls_t;

  localparam cls_t CLS_SPACE = 5'd10;
  localparam cls_t CLS_DOT   = 5'd11;
  localparam cls_t CLS_COLON = 5'd12;
  localparam cls_t CLS_A     = 5'd13;
  localparam cls_t CLS_M     = 5'd14;
  localparam cls_t CLS_P     = 5'd15;
  localparam cls_t CLS_OTHER = 5'd16;

  // One classified word handed from the front to the back.
  typedef struct packed {
    cls_t cls;
    logic present;
    logic last;
  } entry_t;

  // Back sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_SCAN,
    ST_EVAL,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/tdtp_front.sv
// Front of the time-of-day text parser: takes input words and classifies characters.
// Depends on tdtp_pkg; feeds tdtp_queue.
`default_nettype none

module tdtp_front import tdtp_pkg::*; (
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] char_code
  input  wire logic        s_tuser,   // [0] char_present
  input  wire logic        s_tlast,   // text_end
  output logic             push_valid,
  input  wire logic        push_ready,
  output entry_t           push_entry
);

  function automatic cls_t classify(input logic [15:0] c);
    cls_t k;
    k = CLS_OTHER;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      k = {1'b0, c[3:0]};
    end else if (c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D)) begin
      k = CLS_SPACE;
    end else if (c == 16'h002E) begin
      k = CLS_DOT;
    end else if (c == 16'h003A) begin
      k = CLS_COLON;
    end else if (c == 16'h0041 || c == 16'h0061) begin
      k = CLS_A;
    end else if (c == 16'h004D || c == 16'h006D) begin
      k = CLS_M;
    end else if (c == 16'h0050 || c == 16'h0070) begin
      k = CLS_P;
    end
    return k;
  endfunction

  // Drop words that carry no character and close nothing.
  assign s_tready   = push_ready;
  assign push_valid = s_tvalid & (s_tuser | s_tlast);

  always_comb begin
    push_entry.cls     = classify(s_tdata);
    push_entry.present = s_tuser;
    push_entry.last    = s_tlast;
  end

endmodule

`default_nettype wire

>>> sv/tdtp_queue.sv
// Short queue of classified words between the front and the back.
// Depends on tdtp_pkg for entry_t and QUEUE_DEPTH.
`default_nettype none

module tdtp_queue import tdtp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_entry,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output entry_t      pop_entry
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;
  logic            push_fire;
  logic            pop_fire;

  assign push_ready = (fill != NW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push_fire  = push_valid & push_ready;
  assign pop_fire   = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        fill <= fill + 1'b1;
      end else if (pop_fire && !push_fire) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tdtp_back.sv
// Back of the time-of-day text parser: stores the text, scans it and forms the result.
// Depends on tdtp_pkg; drains tdtp_queue and drives the output register.
`default_nettype none

module tdtp_back import tdtp_pkg::*; #(
  parameter int unsigned MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  wire entry_t      pop_entry,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [10:0] minute_of_day, [15:11] zero
  output logic             m_tuser    // [0] time_ok
);

  localparam int unsigned CW = $clog2(MAX_TEXT_CHARS + 1);
  localparam int unsigned IW = $clog2(MAX_TEXT_CHARS);

  back_state_t state, state_next;

  cls_t        mem [MAX_TEXT_CHARS];
  logic [CW-1:0] count;
  logic        ovf;
  logic        any_ns;
  logic [CW-1:0] lo1;
  logic [CW-1:0] hi1;
  cls_t        tail [4];
  cls_t        snap [4];
  cls_t        tail_sh [4];

  logic        has_mer;
  logic        is_pm;
  logic [CW-1:0] scan_end;
  logic [CW-1:0] rd_idx;
  logic        rd_vld;
  cls_t        rd_cls;

  // Scan accumulators.
  logic        sp;
  logic        bad;
  logic        colon;
  logic [2:0]  n_a;
  logic [2:0]  n_b;
  logic [13:0] acc_a;
  logic [13:0] acc_b;
  logic [6:0]  acc_h;
  logic [3:0]  w1;
  logic [3:0]  w0;

  logic        ok_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;

  // Control.
  logic        pop_fire;
  logic        mem_we;
  logic        rd_issue;
  logic        out_load;

  // Suffix and evaluation.
  logic [CW-1:0] len1;
  logic [2:0]  suf_len;
  logic        suf_mer;
  logic        suf_pm;
  logic        form_ok;
  logic [13:0] hour_raw;
  logic [13:0] min_raw;
  logic [13:0] hour_adj;
  logic        eval_ok;
  logic [10:0] mod_sum;
  logic [3:0]  dig;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (pop_valid && pop_entry.last) state_next = ST_PREP;
      ST_PREP: state_next = ST_SCAN;
      ST_SCAN: if (!rd_issue && !rd_vld) state_next = ST_EVAL;
      ST_EVAL: state_next = ST_EMIT;
      ST_EMIT: if (out_load) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_ready = 1'b0;
    rd_issue  = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_LOAD: pop_ready = 1'b1;
      ST_SCAN: rd_issue  = (rd_idx < scan_end);
      ST_EMIT: out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign pop_fire = pop_valid & pop_ready;
  assign mem_we   = pop_fire & pop_entry.present & (count < CW'(MAX_TEXT_CHARS));

  always_comb begin
    tail_sh[0] = pop_entry.cls;
    tail_sh[1] = tail[0];
    tail_sh[2] = tail[1];
    tail_sh[3] = tail[2];
  end

  // Meridiem suffix over the last four non-trailing characters.
  always_comb begin
    len1    = hi1 - lo1;
    suf_len = 3'd0;
    suf_mer = 1'b0;
    suf_pm  = 1'b0;
    priority if (len1 >= CW'(4) && snap[3] == CLS_A && snap[2] == CLS_DOT &&
                 snap[1] == CLS_M && snap[0] == CLS_DOT) begin
      suf_len = 3'd4;
      suf_mer = 1'b1;
    end else if (len1 >= CW'(4) && snap[3] == CLS_P && snap[2] == CLS_DOT &&
                 snap[1] == CLS_M && snap[0] == CLS_DOT) begin
      suf_len = 3'd4;
      suf_mer = 1'b1;
      suf_pm  = 1'b1;
    end else if (len1 >= CW'(2) && snap[1] == CLS_A && snap[0] == CLS_M) begin
      suf_len = 3'd2;
      suf_mer = 1'b1;
    end else if (len1 >= CW'(2) && snap[1] == CLS_P && snap[0] == CLS_M) begin
      suf_len = 3'd2;
      suf_mer = 1'b1;
      suf_pm  = 1'b1;
    end else begin
      suf_len = 3'd0;
    end
  end

  // Form check, meridiem adjust and range check.
  always_comb begin
    form_ok  = 1'b0;
    hour_raw = acc_a;
    min_raw  = '0;
    priority if (colon) begin
      form_ok = (n_a != 3'd0) && (n_a <= 3'(RUN_MAX_DIGITS)) &&
                (n_b != 3'd0) && (n_b <= 3'(RUN_MAX_DIGITS));
      min_raw = acc_b;
    end else if (n_a == 3'd1 || n_a == 3'd2) begin
      form_ok = 1'b1;
    end else if (n_a == 3'd3 || n_a == 3'd4) begin
      form_ok  = 1'b1;
      hour_raw = {7'd0, acc_h};
      min_raw  = 14'({w1, 3'b000}) + 14'({w1, 1'b0}) + 14'(w0);
    end else begin
      form_ok = 1'b0;
    end

    hour_adj = hour_raw;
    if (has_mer && is_pm && hour_raw != 14'(NOON_HOUR)) begin
      hour_adj = hour_raw + 14'(PM_OFFSET);
    end else if (has_mer && !is_pm && hour_raw == 14'(NOON_HOUR)) begin
      hour_adj = '0;
    end

    eval_ok = !bad && form_ok && (hour_adj <= 14'(HOUR_MAX)) &&
              (min_raw <= 14'(MINUTE_MAX));
  end

  // hour * 60 + minute
  assign mod_sum = 11'({hour_r, 6'b0}) - 11'({hour_r, 2'b0}) + 11'(min_r);
  assign dig     = rd_cls[3:0];

  // Text store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= pop_entry.cls;
    end
    if (rd_issue) begin
      rd_cls <= mem[rd_idx[IW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      any_ns   <= 1'b0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_issue;
      if (pop_fire && pop_entry.present) begin
        if (mem_we) begin
          count <= count + 1'b1;
          if (pop_entry.cls != CLS_SPACE) begin
            any_ns <= 1'b1;
          end
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == ST_PREP) begin
        count  <= '0;
        ovf    <= 1'b0;
        any_ns <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tail <= tail_sh;
      if (pop_entry.cls != CLS_SPACE) begin
        snap <= tail_sh;
        hi1  <= count + 1'b1;
        if (!any_ns) begin
          lo1 <= count;
        end
      end
    end

    if (state == ST_PREP) begin
      bad     <= ovf || !any_ns;
      has_mer <= suf_mer;
      is_pm   <= suf_pm;
      // A rejected text scans nothing; its bounds may be stale.
      rd_idx  <= (ovf || !any_ns) ? '0 : lo1;
      scan_end <= (ovf || !any_ns) ? '0 : hi1 - CW'(suf_len);
      sp      <= 1'b0;
      colon   <= 1'b0;
      n_a     <= '0;
      n_b     <= '0;
      acc_a   <= '0;
      acc_b   <= '0;
      acc_h   <= '0;
      w1      <= '0;
      w0      <= '0;
    end

    if (rd_issue) begin
      rd_idx <= rd_idx + 1'b1;
    end

    // Consume one stored character.
    if (state == ST_SCAN && rd_vld) begin
      if (rd_cls <= cls_t'(9)) begin
        if (sp) begin
          bad <= 1'b1;
        end
        if (!colon) begin
          if (n_a < 3'(RUN_MAX_DIGITS)) begin
            acc_a <= 14'({acc_a, 3'b000}) + 14'({acc_a, 1'b0}) + 14'(dig);
            if (n_a >= 3'd2) begin
              acc_h <= 7'({acc_h, 3'b000}) + 7'({acc_h, 1'b0}) + 7'(w1);
            end
            w1 <= w0;
            w0 <= dig;
          end
          if (n_a != 3'd5) begin
            n_a <= n_a + 1'b1;
          end
        end else begin
          if (n_b < 3'(RUN_MAX_DIGITS)) begin
            acc_b <= 14'({acc_b, 3'b000}) + 14'({acc_b, 1'b0}) + 14'(dig);
          end
          if (n_b != 3'd5) begin
            n_b <= n_b + 1'b1;
          end
        end
      end else if (rd_cls == CLS_SPACE) begin
        sp <= 1'b1;
      end else if (rd_cls == CLS_DOT || rd_cls == CLS_COLON) begin
        if (sp || colon) begin
          bad <= 1'b1;
        end
        colon <= 1'b1;
      end else begin
        bad <= 1'b1;
      end
    end

    if (state == ST_EVAL) begin
      ok_r   <= eval_ok;
      hour_r <= hour_adj[4:0];
      min_r  <= min_raw[5:0];
    end

    if (out_load) begin
      m_tuser <= ok_r;
      m_tdata <= ok_r ? {5'd0, mod_sum} : '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/time_of_day_text_parser_top.sv
// Top level of the time-of-day text parser.
// Depends on tdtp_pkg, tdtp_front, tdtp_queue and tdtp_back.
//
// Usage:
//   Input stream (s_*): one UTF-16 code unit per word in s_tdata, s_tuser
//   set when the word carries a character, s_tlast on the final word of a
//   text. A word with neither s_tuser nor s_tlast is dropped.
//   Output stream (m_*): one word per text, after its s_tlast word.
//   m_tuser is the valid flag, m_tdata[10:0] the minute of the day (zero
//   when the text is rejected).
//   Sequencing: characters are stored at one per cycle while the back
//   sequencer is in its load state. After the last word the back passes
//   through the queue, a prep state, a scan of the characters between the
//   first non-space character and the end of the body followed by a drain
//   of the read pipeline, an evaluate state and the load of the output
//   register. The back takes no words from the queue between a text's
//   last word and the load of its result, so the next text waits there.
//   Reset (rst, synchronous, active high) empties the queue, clears the
//   character count and drops any pending result; the store needs no pass.
//   Stall: a held result waits in the output register; the queue keeps
//   taking words until it fills, then s_tready drops.
`default_nettype none

module time_of_day_text_parser_top import tdtp_pkg::*; #(
  parameter int unsigned MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] char_code
  input  wire logic        s_tuser,   // [0] char_present
  input  wire logic        s_tlast,   // text_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [10:0] minute_of_day, [15:11] zero
  output logic             m_tuser    // [0] time_ok
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // Classify characters on the way in.
  tdtp_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // Decouple the front from the back while a text is being scanned.
  tdtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Store, scan and emit one result per text.
  tdtp_back #(
    .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire
